// ===== hdl/raster_path_point_generator_core_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef RASTER_PATH_POINT_GENERATOR_CORE_MACROS_SVH
`define RASTER_PATH_POINT_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define RPPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rppg assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is low
`define RPPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rppg assertion failed (next cycle)");

`endif

// ===== hdl/rppg_pkg.sv =====
// Shared types, constants and tables of the raster path point generator
`timescale 1ns / 1ps
package rppg_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int DIR_SHIFT    = 30 - FRAC_BITS;
  localparam int DIV_BITS     = 32;

  // (pi/2 - 1) in Q32, fractional part of (pi - 1) in Q31 (integer part is 2)
  localparam logic [31:0] HALF_PI_M1_Q32 = 32'h921FB544;
  localparam logic [28:0] PI_M1_FRAC_Q31 = 29'h121FB544;

  localparam logic [31:0]        PI_Q30      = 32'd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sh026DD3B6A;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [32:0]        POS_MAX     = 33'h1_FFFF_FFFF;

  localparam logic signed [32:0] DIR_RND = 33'sd1 <<< (DIR_SHIFT - 1);
  localparam logic signed [17:0] DIR_ONE = 18'sd1 <<< FRAC_BITS;

  // round(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  localparam logic CFG_SIDE = 1'b0;
  localparam logic CFG_TURN = 1'b1;

  typedef enum logic [1:0] {
    SEG_OUT  = 2'd0,
    SEG_TURN = 2'd1,
    SEG_RET  = 2'd2
  } seg_t;

  // Per-transaction sideband that rides along the turn pipeline
  typedef struct packed {
    seg_t        seg;
    logic        sig_pos;
    logic [32:0] px_base;
    logic [31:0] py_lin;
  } ctx_t;

endpackage

// ===== hdl/rppg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rppg_div import rppg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [31:0] in_rem,
  input  logic [31:0] in_lo,
  input  logic [31:0] divisor,
  input  ctx_t        in_ctx,
  output logic        out_vld,
  output logic [31:0] out_quo,
  output logic [31:0] out_rem,
  output ctx_t        out_ctx
);

  logic        vld_r [DIV_BITS];
  logic [31:0] rem_r [DIV_BITS];
  logic [31:0] lo_r  [DIV_BITS];
  logic [31:0] quo_r [DIV_BITS];
  ctx_t        ctx_r [DIV_BITS];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
    logic        prev_vld;
    logic [31:0] prev_rem;
    logic [31:0] prev_lo;
    logic [31:0] prev_quo;
    ctx_t        prev_ctx;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    if (i == 0) begin : g_first
      assign prev_vld = in_vld;
      assign prev_rem = in_rem;
      assign prev_lo  = in_lo;
      assign prev_quo = '0;
      assign prev_ctx = in_ctx;
    end else begin : g_next
      assign prev_vld = vld_r[i-1];
      assign prev_rem = rem_r[i-1];
      assign prev_lo  = lo_r[i-1];
      assign prev_quo = quo_r[i-1];
      assign prev_ctx = ctx_r[i-1];
    end

    assign trial = {prev_rem, prev_lo[31]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= ge ? diff[31:0] : trial[31:0];
        lo_r[i]  <= {prev_lo[30:0], 1'b0};
        quo_r[i] <= {prev_quo[30:0], ge};
        ctx_r[i] <= prev_ctx;
      end
    end
  end

  assign out_vld = vld_r[DIV_BITS-1];
  assign out_quo = quo_r[DIV_BITS-1];
  assign out_rem = rem_r[DIV_BITS-1];
  assign out_ctx = ctx_r[DIV_BITS-1];

endmodule

// ===== hdl/rppg_cls.sv =====
// Segment selection, sweep offset multiply and line-segment position
`timescale 1ns / 1ps
module rppg_cls import rppg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [31:0]        cyc_cnt,
  input  logic [31:0]        cyc_rem,
  input  logic [31:0]        lc,
  input  logic signed [31:0] b0,
  input  logic [32:0]        b1,
  input  logic [30:0]        turnw,
  output logic               out_vld,
  output logic [33:0]        out_u,
  output ctx_t               out_ctx
);

  // stage A: classify
  logic signed [34:0] l2;
  logic signed [34:0] b0_ext;
  logic signed [34:0] b1_ext;
  logic signed [34:0] u_full;
  seg_t               seg_nxt;

  logic        a_vld_r;
  seg_t        a_seg_r;
  logic [31:0] a_n_r;
  logic [33:0] a_u_r;
  logic [31:0] a_pylin_r;

  assign l2     = signed'({2'b00, cyc_rem, 1'b0});
  assign b0_ext = 35'(b0);
  assign b1_ext = signed'({2'b00, b1});
  assign u_full = l2 - b0_ext;

  always_comb begin
    if (l2 < b0_ext) begin
      seg_nxt = SEG_OUT;
    end else if (l2 < b1_ext) begin
      seg_nxt = SEG_TURN;
    end else begin
      seg_nxt = SEG_RET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_seg_r   <= seg_nxt;
      a_n_r     <= cyc_cnt;
      a_u_r     <= u_full[33:0];
      a_pylin_r <= (seg_nxt == SEG_RET) ? (lc - cyc_rem) : cyc_rem;
    end
  end

  // stage B: sweep offset N*V
  logic        b_vld_r;
  seg_t        b_seg_r;
  logic        b_sig_r;
  logic [62:0] b_nv_r;
  logic [33:0] b_u_r;
  logic [31:0] b_pylin_r;
  logic [62:0] nv_nxt;

  assign nv_nxt = a_n_r * turnw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_seg_r   <= a_seg_r;
      b_sig_r   <= a_n_r[0];
      b_nv_r    <= nv_nxt;
      b_u_r     <= a_u_r;
      b_pylin_r <= a_pylin_r;
    end
  end

  // stage C: base x position, saturated
  logic [63:0] px_sum;
  ctx_t        ctx_nxt;
  logic        c_vld_r;
  logic [33:0] c_u_r;
  ctx_t        c_ctx_r;

  assign px_sum = {1'b0, b_nv_r} + ((b_seg_r == SEG_RET) ? {33'd0, turnw} : 64'd0);

  always_comb begin
    ctx_nxt.seg     = b_seg_r;
    ctx_nxt.sig_pos = b_sig_r;
    ctx_nxt.px_base = (px_sum > {31'd0, POS_MAX}) ? POS_MAX : px_sum[32:0];
    ctx_nxt.py_lin  = b_pylin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_u_r   <= b_u_r;
      c_ctx_r <= ctx_nxt;
    end
  end

  assign out_vld = c_vld_r;
  assign out_u   = c_u_r;
  assign out_ctx = c_ctx_r;

endmodule

// ===== hdl/rppg_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per stage
`timescale 1ns / 1ps
module rppg_cordic import rppg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [31:0]        theta,
  input  ctx_t               in_ctx,
  output logic               out_vld,
  output logic signed [33:0] out_cos,
  output logic signed [33:0] out_sin,
  output ctx_t               out_ctx
);

  logic               vld_r [CORDIC_STEPS+1];
  logic signed [33:0] x_r   [CORDIC_STEPS+1];
  logic signed [33:0] y_r   [CORDIC_STEPS+1];
  logic signed [33:0] z_r   [CORDIC_STEPS+1];
  ctx_t               ctx_r [CORDIC_STEPS+1];

  logic [31:0] th_cap;

  // cap the angle at pi and shift it into [-pi/2, pi/2]
  assign th_cap = (theta > PI_Q30) ? PI_Q30 : theta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]   <= GAIN_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= signed'({2'b00, th_cap}) - HALF_PI_Q30;
      ctx_r[0] <= in_ctx;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] ang;

    assign dx  = y_r[i] >>> i;
    assign dy  = x_r[i] >>> i;
    assign ang = signed'({2'b00, ATAN_Q30[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ang;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ang;
        end
        ctx_r[i+1] <= ctx_r[i];
      end
    end
  end

  assign out_vld = vld_r[CORDIC_STEPS];
  assign out_cos = x_r[CORDIC_STEPS];
  assign out_sin = y_r[CORDIC_STEPS];
  assign out_ctx = ctx_r[CORDIC_STEPS];

endmodule

// ===== hdl/rppg_out.sv =====
// Turn position scaling, tangent rounding and the output register
`timescale 1ns / 1ps
module rppg_out import rppg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic signed [33:0] in_cos,
  input  logic signed [33:0] in_sin,
  input  ctx_t               in_ctx,
  input  logic [30:0]        turnw,
  input  logic signed [31:0] b0,
  input  logic               lc_zero,
  output logic               out_vld,
  output logic signed [33:0] out_pos_x,
  output logic signed [33:0] out_pos_y,
  output logic signed [17:0] out_dir_x,
  output logic signed [17:0] out_dir_y,
  output seg_t               out_seg,
  output logic               out_err
);

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > ONE_Q30) begin
      r = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      r = -ONE_Q30;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  // stage M1: clamp and the two scale multiplies
  logic signed [31:0] c_cl;
  logic signed [31:0] s_cl;
  logic signed [33:0] one_plus_s;
  logic [62:0]        prod1_nxt;
  logic signed [63:0] prod2_nxt;

  logic               m_vld_r;
  logic signed [31:0] m_c_r;
  logic signed [31:0] m_s_r;
  logic [62:0]        m_prod1_r;
  logic signed [63:0] m_prod2_r;
  ctx_t               m_ctx_r;

  assign c_cl       = clamp_q30(in_cos);
  assign s_cl       = clamp_q30(in_sin);
  assign one_plus_s = ONE_Q30 + 34'(s_cl);
  assign prod1_nxt  = turnw * one_plus_s[31:0];
  assign prod2_nxt  = signed'({1'b0, turnw}) * c_cl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_c_r     <= c_cl;
      m_s_r     <= s_cl;
      m_prod1_r <= prod1_nxt;
      m_prod2_r <= prod2_nxt;
      m_ctx_r   <= in_ctx;
    end
  end

  // stage M2: combine into the result
  logic [62:0]        p1_rnd;
  logic [34:0]        px_sum;
  logic [32:0]        px_turn;
  logic signed [65:0] py_sum;
  logic signed [33:0] py_half;
  logic signed [33:0] py_turn;
  logic signed [33:0] py_line;
  logic signed [31:0] dy_src;
  logic signed [32:0] dx_rnd;
  logic signed [32:0] dy_rnd;
  logic signed [32:0] dx_sh;
  logic signed [32:0] dy_sh;
  logic               dy_line_pos;

  logic signed [33:0] pos_x_nxt;
  logic signed [33:0] pos_y_nxt;
  logic signed [17:0] dir_x_nxt;
  logic signed [17:0] dir_y_nxt;
  seg_t               seg_nxt;

  logic               vld_r;
  logic signed [33:0] pos_x_r;
  logic signed [33:0] pos_y_r;
  logic signed [17:0] dir_x_r;
  logic signed [17:0] dir_y_r;
  seg_t               seg_r;
  logic               err_r;

  assign p1_rnd  = m_prod1_r + {32'd0, 1'b1, 30'd0};
  assign px_sum  = {2'b00, m_ctx_r.px_base} + {3'd0, p1_rnd[62:31]};
  assign px_turn = (px_sum > {2'b00, POS_MAX}) ? POS_MAX : px_sum[32:0];

  assign py_sum  = {{4{b0[31]}}, b0, 30'd0} + {{2{m_prod2_r[63]}}, m_prod2_r}
                 + {35'd0, 1'b1, 30'd0};
  assign py_half = py_sum[64:31];
  assign py_turn = m_ctx_r.sig_pos ? py_half : -py_half;
  assign py_line = m_ctx_r.sig_pos ? signed'({2'b00, m_ctx_r.py_lin})
                                   : -signed'({2'b00, m_ctx_r.py_lin});

  // tangent y on the turn is -sin for an odd sweep
  assign dy_src = m_ctx_r.sig_pos ? -m_s_r : m_s_r;
  assign dx_rnd = 33'(m_c_r) + DIR_RND;
  assign dy_rnd = 33'(dy_src) + DIR_RND;
  assign dx_sh  = dx_rnd >>> DIR_SHIFT;
  assign dy_sh  = dy_rnd >>> DIR_SHIFT;

  assign dy_line_pos = (m_ctx_r.seg == SEG_OUT) ? m_ctx_r.sig_pos : !m_ctx_r.sig_pos;

  always_comb begin
    seg_nxt = m_ctx_r.seg;
    case (m_ctx_r.seg)
      SEG_TURN: begin
        pos_x_nxt = signed'({1'b0, px_turn});
        pos_y_nxt = py_turn;
        dir_x_nxt = dx_sh[17:0];
        dir_y_nxt = dy_sh[17:0];
      end
      default: begin
        pos_x_nxt = signed'({1'b0, m_ctx_r.px_base});
        pos_y_nxt = py_line;
        dir_x_nxt = '0;
        dir_y_nxt = dy_line_pos ? DIR_ONE : -DIR_ONE;
      end
    endcase
    // zero cycle length: drop everything but the flag
    if (lc_zero) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
      dir_x_nxt = '0;
      dir_y_nxt = '0;
      seg_nxt   = SEG_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      dir_x_r <= dir_x_nxt;
      dir_y_r <= dir_y_nxt;
      seg_r   <= seg_nxt;
      err_r   <= lc_zero;
    end
  end

  assign out_vld   = vld_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_dir_x = dir_x_r;
  assign out_dir_y = dir_y_r;
  assign out_seg   = seg_r;
  assign out_err   = err_r;

endmodule

// ===== hdl/raster_path_point_generator_core.sv =====
// Serpentine raster path point generator, top level
// Pipeline: input register, 32-stage cycle divider, 3 classify stages, 32-stage angle divider,
//   17 CORDIC stages and 2 output stages.
// Throughput: one transaction per cycle; a stalled result freezes the whole pipeline.
// Reset: synchronous, active low; clears all stage valids and loads the default
//   side length (10.0) and turn width (1.0).
`timescale 1ns / 1ps
module raster_path_point_generator_core import rppg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_arc_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [33:0] out_pos_x,
  output logic signed [33:0] out_pos_y,
  output logic signed [17:0] out_dir_x,
  output logic signed [17:0] out_dir_y,
  output logic [1:0]         out_segment,
  output logic               out_error,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);

  logic adv;

  // configuration registers
  logic [30:0] side_r;
  logic [30:0] turnw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= 31'd655360;
      turnw_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIDE: side_r  <= cfg_wdata;
        CFG_TURN: turnw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // derived cycle constants, registered in the cycle after a write
  logic [62:0]        lc_prod;
  logic [62:0]        lc_prod_rnd;
  logic [31:0]        lc_nxt;
  logic [59:0]        b1_frac;
  logic [63:0]        b1_prod;
  logic [63:0]        b1_prod_rnd;
  logic [32:0]        b1_nxt;
  logic [31:0]        lc_r;
  logic signed [31:0] b0_r;
  logic [32:0]        b1_r;
  logic               lcz_r;

  assign lc_prod     = turnw_r * HALF_PI_M1_Q32;
  assign lc_prod_rnd = lc_prod + {31'd0, 1'b1, 31'd0};
  assign lc_nxt      = {1'b0, side_r} + {1'b0, lc_prod_rnd[62:32]};
  assign b1_frac     = turnw_r * PI_M1_FRAC_Q31;
  assign b1_prod     = {1'b0, turnw_r, 32'd0} + {4'd0, b1_frac};
  assign b1_prod_rnd = b1_prod + {33'd0, 1'b1, 30'd0};
  assign b1_nxt      = {2'b00, side_r} + b1_prod_rnd[63:31];

  always_ff @(posedge clk) begin
    lc_r  <= lc_nxt;
    b0_r  <= signed'({1'b0, side_r}) - signed'({1'b0, turnw_r});
    b1_r  <= b1_nxt;
    lcz_r <= (lc_nxt == 32'd0);
  end

  // pipeline advances unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // input register: magnitude of the position
  logic        s0_vld_r;
  logic [31:0] s0_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_t_r <= in_arc_position[31] ? (32'd0 - in_arc_position) : in_arc_position;
    end
  end

  // cycle count and remainder
  logic        d1_vld;
  logic [31:0] d1_quo;
  logic [31:0] d1_rem;
  ctx_t        d1_ctx;

  rppg_div u_div_cyc (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (s0_vld_r),
    .in_rem  (32'd0),
    .in_lo   (s0_t_r),
    .divisor (lc_r),
    .in_ctx  ('0),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_rem (d1_rem),
    .out_ctx (d1_ctx)
  );

  logic        cl_vld;
  logic [33:0] cl_u;
  ctx_t        cl_ctx;

  rppg_cls u_cls (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (d1_vld),
    .cyc_cnt (d1_quo),
    .cyc_rem (d1_rem),
    .lc      (lc_r),
    .b0      (b0_r),
    .b1      (b1_r),
    .turnw   (turnw_r),
    .out_vld (cl_vld),
    .out_u   (cl_u),
    .out_ctx (cl_ctx)
  );

  // turn angle (u << 30) / V
  logic        d2_vld;
  logic [31:0] d2_quo;
  logic [31:0] d2_rem;
  ctx_t        d2_ctx;

  rppg_div u_div_ang (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (cl_vld),
    .in_rem  (cl_u[33:2]),
    .in_lo   ({cl_u[1:0], 30'd0}),
    .divisor ({1'b0, turnw_r}),
    .in_ctx  (cl_ctx),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_rem (d2_rem),
    .out_ctx (d2_ctx)
  );

  logic               co_vld;
  logic signed [33:0] co_cos;
  logic signed [33:0] co_sin;
  ctx_t               co_ctx;

  rppg_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (d2_vld),
    .theta   (d2_quo),
    .in_ctx  (d2_ctx),
    .out_vld (co_vld),
    .out_cos (co_cos),
    .out_sin (co_sin),
    .out_ctx (co_ctx)
  );

  seg_t seg_out;

  rppg_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (co_vld),
    .in_cos    (co_cos),
    .in_sin    (co_sin),
    .in_ctx    (co_ctx),
    .turnw     (turnw_r),
    .b0        (b0_r),
    .lc_zero   (lcz_r),
    .out_vld   (out_valid),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_dir_x (out_dir_x),
    .out_dir_y (out_dir_y),
    .out_seg   (seg_out),
    .out_err   (out_error)
  );

  assign out_segment = seg_out;

  // the angle divider's remainder and the cycle divider's sideband are not needed
  logic unused_ok;
  assign unused_ok = ^{d2_rem, d1_ctx};

endmodule

// ===== hdl/rppg_chk.sv =====
// Port-level checker for the raster path point generator, bound to the top level
`timescale 1ns / 1ps
`include "raster_path_point_generator_core_macros.svh"
module rppg_chk import rppg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [33:0] out_pos_x,
  input logic signed [33:0] out_pos_y,
  input logic signed [17:0] out_dir_x,
  input logic signed [17:0] out_dir_y,
  input logic [1:0]         out_segment,
  input logic               out_error
);

  // a held result stays held
  `RPPG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // a held result back-pressures the input side in the same cycle
  `RPPG_ASSERT_IMP(a_stall_prop, clk, rst_n, out_valid && out_stall, in_stall)

  // an error transaction carries only the flag
  `RPPG_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_error,
    out_pos_x == 34'sd0 && out_pos_y == 34'sd0 && out_dir_x == 18'sd0 &&
    out_dir_y == 18'sd0 && out_segment == SEG_OUT)

  // straight segments point purely along y with unit length
  `RPPG_ASSERT_IMP(a_line_dir, clk, rst_n,
    out_valid && !out_error && out_segment != SEG_TURN,
    out_dir_x == 18'sd0 && (out_dir_y == DIR_ONE || out_dir_y == -DIR_ONE))

endmodule

bind raster_path_point_generator_core rppg_chk u_rppg_chk (.*);

// ===== sim/raster_point_checker.sv =====
// Checker for the raster path point generator: predicts each point and compares results
`timescale 1ns / 1ps
module raster_point_checker import rppg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_arc_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [33:0] out_pos_x,
  input  logic signed [33:0] out_pos_y,
  input  logic signed [17:0] out_dir_x,
  input  logic signed [17:0] out_dir_y,
  input  logic [1:0]         out_segment,
  input  logic               out_error,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  output int                 mismatches,
  output int                 pending,
  output int                 points_checked
);

  typedef struct packed {
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    seg_t               seg;
    logic               err;
  } point_t;

  localparam longint ONE30  = 64'sd1 << 30;
  localparam longint PMAX   = (64'sd1 <<< 33) - 1;
  localparam longint PMIN   = -(64'sd1 <<< 33);
  localparam longint DONE   = 64'sd1 <<< FRAC_BITS;

  longint unsigned side_len, turn_wid;
  point_t expected_points[$];
  longint atan_lut [CORDIC_STEPS];

  function automatic longint atan_entry(int i);
    longint unsigned acc, term;
    int e;
    acc = 0;
    if (i == 0) return 64'sd843314857;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
      if (k % 2) acc -= term;
      else acc += term;
    end
    return longint'((acc + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint to_dir(longint v);
    return clip((v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS), -DONE, DONE);
  endfunction

  function automatic point_t predict_point(logic signed [31:0] arc);
    point_t p;
    longint unsigned t, lc, n, l, u, b1u;
    longint sig, l2, b0, b1, px, py, dx, dy, theta, x, y, z, ddx, ddy;
    p = '0;
    t = arc[31] ? longint'(-longint'(arc)) : longint'(arc);
    lc = side_len + ((turn_wid * 64'h921FB544 + (64'd1 << 31)) >> 32);
    if (lc == 0) begin
      p.err = 1'b1;
      return p;
    end
    n = t / lc;
    l = t - n * lc;
    sig = n[0] ? 1 : -1;
    l2 = longint'(2 * l);
    b0 = longint'(side_len) - longint'(turn_wid);
    b1u = (turn_wid * 64'h1121FB544 + (64'd1 << 30)) >> 31;
    b1 = longint'(side_len) + longint'(b1u);
    if (l2 < b0) begin
      p.seg = SEG_OUT;
      px = longint'(n * turn_wid);
      py = sig * longint'(l);
      dx = 0;
      dy = sig * DONE;
    end else if (l2 < b1) begin
      p.seg = SEG_TURN;
      u = longint'(l2 - b0);
      theta = longint'((u << 30) / turn_wid);
      if (theta > 64'sd3373259426) theta = 64'sd3373259426;
      x = 64'sh26DD3B6A;
      y = 0;
      z = theta - 64'sd1686629713;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        ddx = y >>> i;
        ddy = x >>> i;
        if (z >= 0) begin
          x -= ddx; y += ddy; z -= atan_lut[i];
        end else begin
          x += ddx; y -= ddy; z += atan_lut[i];
        end
      end
      x = clip(x, -ONE30, ONE30);
      y = clip(y, -ONE30, ONE30);
      // x holds sin(theta), y holds -cos(theta)
      px = longint'(n * turn_wid)
         + longint'((turn_wid * longint'(ONE30 + y) + (64'd1 << 30)) >> 31);
      py = sig * ((b0 * ONE30 + longint'(turn_wid) * x + ONE30) >>> 31);
      dx = to_dir(x);
      dy = to_dir(sig > 0 ? -y : y);
    end else begin
      p.seg = SEG_RET;
      px = longint'((n + 1) * turn_wid);
      py = sig * longint'(lc - l);
      dx = 0;
      dy = -sig * DONE;
    end
    p.px = 34'(clip(px, PMIN, PMAX));
    p.py = 34'(clip(py, PMIN, PMAX));
    p.dx = 18'(dx);
    p.dy = 18'(dy);
    return p;
  endfunction

  initial begin
    for (int i = 0; i < CORDIC_STEPS; i++) atan_lut[i] = atan_entry(i);
    mismatches = 0;
    points_checked = 0;
  end

  assign pending = expected_points.size();

  always @(posedge clk) begin
    point_t e, a;
    if (!rst_n) begin
      side_len <= 655360;
      turn_wid <= 65536;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SIDE) side_len <= cfg_wdata;
        else turn_wid <= cfg_wdata;
      end
      if (in_valid && !in_stall) expected_points.push_back(predict_point(in_arc_position));
      if (out_valid && !out_stall) begin
        a = '{out_pos_x, out_pos_y, out_dir_x, out_dir_y, seg_t'(out_segment), out_error};
        points_checked++;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", a);
        end else begin
          e = expected_points.pop_front();
          if (e != a) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: px %0d/%0d py %0d/%0d dx %0d/%0d dy %0d/%0d seg %0d/%0d err %0b/%0b",
                       e.px, a.px, e.py, a.py, e.dx, a.dx, e.dy, a.dy,
                       e.seg, a.seg, e.err, a.err);
          end
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: stimulus, configuration phases and verdict for the raster path point generator
`timescale 1ns / 1ps
module testbench import rppg_pkg::*;;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_arc_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [33:0] out_pos_x, out_pos_y;
  logic signed [17:0] out_dir_x, out_dir_y;
  logic [1:0]         out_segment;
  logic               out_error;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = CFG_SIDE;
  logic [30:0]        cfg_wdata = '0;

  int mismatches, pending, points_checked;
  int send_gap_pct = 0, recv_stall_pct = 0;
  int cycles = 0;
  int n_sent = 0, n_configs = 0;
  longint unsigned side_now = 655360, turn_now = 65536;

  raster_path_point_generator_core dut (.*);

  raster_point_checker checker_i (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_position(logic signed [31:0] arc);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_arc_position <= arc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic load_geometry(longint unsigned side, longint unsigned turn);
    drain_pipeline();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SIDE;
    cfg_wdata <= side[30:0];
    @(negedge clk);
    cfg_index <= CFG_TURN;
    cfg_wdata <= turn[30:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    side_now = side;
    turn_now = turn;
    n_configs++;
  endtask

  // Mostly positions within a few cycles of the path, some anywhere in range
  function automatic logic signed [31:0] random_position();
    longint unsigned span;
    logic [31:0] r;
    span = 6 * (side_now + turn_now) + 16;
    if (span > 64'h7FFF_FFFF || $urandom_range(3) == 0) return $urandom;
    r = $urandom_range(0, int'(span));
    return $urandom_range(1) ? -r : r;
  endfunction

  initial begin
    longint unsigned sides [6] = '{655360, 0, 31'h7FFF_FFFF, 65536, 31'h7FFF_FFFF, 3000};
    longint unsigned turns [6] = '{65536, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 5000};
    logic signed [31:0] directed [20] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
      32'sd294911, 32'sd294912, 32'sd300000, 32'sd327680, 32'sd360000,
      32'sd655359, 32'sd655360, 32'sd692767, 32'sd692768, -32'sd692769,
      32'sd1000000, -32'sd1020000, 32'sd1385536, 32'sh5555_5555, 32'shAAAA_AAAA};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_position(directed[i]);

    for (int ph = 0; ph < 6; ph++) begin
      send_gap_pct   = ph < 2 ? 10 : (ph < 4 ? 64 : 0);
      recv_stall_pct = ph < 2 ? 64 : (ph < 4 ? 10 : 0);
      load_geometry(sides[ph], turns[ph]);
      for (int k = 0; k < 65; k++) begin
        // hold off once until the pipeline is empty
        if (ph == 3 && k == 30) begin
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        send_position(ph == 5 && k < 10 ? (k % 2 ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                        : random_position());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d positions over %0d geometries, %0d results checked.",
             n_sent, n_configs, points_checked);
    $display("Geometries included zero cycle length, maximum registers and turn wider than side.");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
